[sv/cstl_pkg.sv]
// Shared types, sizes and character classes for the C subset token lexer.
package cstl_pkg;

  // Sizes
  localparam int MAX_TEXT   = 64;
  localparam int MAX_TOKENS = 256;
  localparam int MAX_SOURCE = 1024;

  localparam int LEN_W = $clog2(MAX_TEXT);
  localparam int CNT_W = $clog2(MAX_TOKENS);
  localparam int POS_W = $clog2(MAX_SOURCE);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TEXT - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKENS - 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SOURCE - 1);

  // Output queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_INT    = 3'd0,
    KIND_RETURN = 3'd1,
    KIND_IDENT  = 3'd2,
    KIND_NUMBER = 3'd3,
    KIND_SYMBOL = 3'd4,
    KIND_END    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  typedef struct packed {
    kind_t             kind;
    logic [31:0]       num_value;
    logic [7:0]        sym_char;
    logic [POS_W-1:0]  start_pos;
    logic [LEN_W-1:0]  text_len;
    logic [CNT_W-1:0]  token_index;
    logic              overflow;
    logic              last_of_run;
  } tok_t;

  localparam logic [7:0] CH_END = 8'h00;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == "(" || c == ")" || c == ";" || c == "{" || c == "}" ||
           c == "+" || c == "-" || c == "*" || c == "/";
  endfunction

  // Expected character of "int" at a position
  function automatic logic [7:0] kw_int_char(input logic [1:0] p);
    logic [7:0] c;
    unique case (p)
      2'd0:    c = "i";
      2'd1:    c = "n";
      2'd2:    c = "t";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Expected character of "return" at a position
  function automatic logic [7:0] kw_ret_char(input logic [2:0] p);
    logic [7:0] c;
    unique case (p)
      3'd0:    c = "r";
      3'd1:    c = "e";
      3'd2:    c = "t";
      3'd3:    c = "u";
      3'd4:    c = "r";
      3'd5:    c = "n";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[sv/c_subset_token_lexer_unit.sv]
// Streaming lexer for a small C subset: one source byte in, up to two tokens out.
//
//  channel | ports                                   | dir | transfer
//  --------+-----------------------------------------+-----+-----------------------
//  input   | in_valid, in_ready, in_ch               | in  | one source byte
//  result  | out_valid, out_ready, out_kind ...      | out | one token record
//
// Each accepted byte updates the scan state in the same cycle and writes its 0, 1
// or 2 token records into a 4-entry output queue; one record leaves per cycle with
// out_ready high. A byte is taken every cycle while the queue has room for two
// records, so the sustained rate is 1 byte per cycle, bounded by 1 token per cycle
// at the output. Reset empties the queue and returns the scanner to idle at
// offset 0. A stalled output fills the queue and drops in_ready; no state is lost.
module c_subset_token_lexer_unit
  import cstl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_ch,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               out_kind,
  output logic signed [31:0]       out_num_value,
  output logic [7:0]               out_sym_char,
  output logic [9:0]               out_start_pos,
  output logic [5:0]               out_text_len,
  output logic [7:0]               out_token_index,
  output logic                     out_overflow,
  output logic                     out_last_of_run
);

  // Scanner state
  mode_t             mode_r, mode_nxt;
  logic [31:0]       accum_r, accum_nxt;
  logic [POS_W-1:0]  tok_start_r, tok_start_nxt;
  logic [LEN_W-1:0]  tok_len_r, tok_len_nxt;
  logic              int_ok_r, int_ok_nxt;
  logic              ret_ok_r, ret_ok_nxt;
  logic [POS_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [CNT_W-1:0]  tok_cnt_r, tok_cnt_nxt;
  logic              ovf_r, ovf_nxt;

  // Output queue
  tok_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;

  // Per-byte results
  tok_t              res_a, res_b;
  logic              a_v, b_v;
  logic              ext_id, ext_num;
  logic [CNT_W-1:0]  cnt_mid;
  logic              ovf_mid;
  kind_t             id_kind;
  logic              in_fire, out_fire;
  tok_t              ent0, ent1;
  logic [1:0]        push_n;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  assign ext_id  = (mode_r == MODE_IDENT) && (is_letter(in_ch) || is_digit(in_ch));
  assign ext_num = (mode_r == MODE_NUMBER) && is_digit(in_ch);

  // Kind of the open identifier
  always_comb begin
    priority if (int_ok_r && tok_len_r == LEN_W'(3)) begin
      id_kind = KIND_INT;
    end else if (ret_ok_r && tok_len_r == LEN_W'(6)) begin
      id_kind = KIND_RETURN;
    end else begin
      id_kind = KIND_IDENT;
    end
  end

  // Next scan state and the records caused by this byte
  always_comb begin
    mode_nxt      = mode_r;
    accum_nxt     = accum_r;
    tok_start_nxt = tok_start_r;
    tok_len_nxt   = tok_len_r;
    int_ok_nxt    = int_ok_r;
    ret_ok_nxt    = ret_ok_r;
    byte_pos_nxt  = (byte_pos_r != POS_MAX) ? byte_pos_r + POS_W'(1) : byte_pos_r;
    tok_cnt_nxt   = tok_cnt_r;
    ovf_nxt       = ovf_r;
    cnt_mid       = tok_cnt_r;
    ovf_mid       = ovf_r;
    a_v           = 1'b0;
    b_v           = 1'b0;
    res_a         = '0;
    res_b         = '0;

    if (ext_id || ext_num) begin
      if (ext_id) begin
        int_ok_nxt = int_ok_r && (tok_len_r < LEN_W'(3)) &&
                     (in_ch == kw_int_char(tok_len_r[1:0]));
        ret_ok_nxt = ret_ok_r && (tok_len_r < LEN_W'(6)) &&
                     (in_ch == kw_ret_char(tok_len_r[2:0]));
      end else begin
        accum_nxt = (accum_r << 3) + (accum_r << 1) + {28'd0, in_ch[3:0]};
      end
      if (tok_len_r != LEN_MAX) begin
        tok_len_nxt = tok_len_r + LEN_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end else begin
      // Close the open token, if any
      if (mode_r != MODE_IDLE) begin
        if (tok_cnt_r == CNT_MAX) begin
          ovf_mid = 1'b1;
        end else begin
          a_v               = 1'b1;
          res_a.kind        = (mode_r == MODE_IDENT) ? id_kind : KIND_NUMBER;
          res_a.num_value   = (mode_r == MODE_NUMBER) ? accum_r : 32'd0;
          res_a.start_pos   = tok_start_r;
          res_a.text_len    = tok_len_r;
          res_a.token_index = tok_cnt_r;
          res_a.overflow    = ovf_r;
          cnt_mid           = tok_cnt_r + CNT_W'(1);
        end
      end
      mode_nxt    = MODE_IDLE;
      tok_cnt_nxt = cnt_mid;
      ovf_nxt     = ovf_mid;

      if (in_ch == CH_END) begin
        // End of source: emit end record and restart
        b_v               = 1'b1;
        res_b.kind        = KIND_END;
        res_b.start_pos   = byte_pos_r;
        res_b.token_index = cnt_mid;
        res_b.overflow    = ovf_mid;
        mode_nxt          = MODE_IDLE;
        accum_nxt         = '0;
        tok_start_nxt     = '0;
        tok_len_nxt       = '0;
        int_ok_nxt        = 1'b0;
        ret_ok_nxt        = 1'b0;
        byte_pos_nxt      = '0;
        tok_cnt_nxt       = '0;
        ovf_nxt           = 1'b0;
      end else if (is_letter(in_ch)) begin
        mode_nxt      = MODE_IDENT;
        tok_start_nxt = byte_pos_r;
        tok_len_nxt   = LEN_W'(1);
        int_ok_nxt    = (in_ch == "i");
        ret_ok_nxt    = (in_ch == "r");
        accum_nxt     = '0;
      end else if (is_digit(in_ch)) begin
        mode_nxt      = MODE_NUMBER;
        tok_start_nxt = byte_pos_r;
        tok_len_nxt   = LEN_W'(1);
        int_ok_nxt    = 1'b0;
        ret_ok_nxt    = 1'b0;
        accum_nxt     = {28'd0, in_ch[3:0]};
      end else if (is_symbol(in_ch)) begin
        if (cnt_mid == CNT_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          b_v               = 1'b1;
          res_b.kind        = KIND_SYMBOL;
          res_b.sym_char    = in_ch;
          res_b.start_pos   = byte_pos_r;
          res_b.text_len    = LEN_W'(1);
          res_b.token_index = cnt_mid;
          res_b.overflow    = ovf_mid;
          tok_cnt_nxt       = cnt_mid + CNT_W'(1);
        end
      end
    end

    res_a.last_of_run = !b_v;
    res_b.last_of_run = 1'b1;
  end

  // Pack the records into queue order
  assign ent0   = a_v ? res_a : res_b;
  assign ent1   = res_b;
  assign push_n = in_fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      accum_r     <= '0;
      tok_start_r <= '0;
      tok_len_r   <= '0;
      int_ok_r    <= 1'b0;
      ret_ok_r    <= 1'b0;
      byte_pos_r  <= '0;
      tok_cnt_r   <= '0;
      ovf_r       <= 1'b0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      accum_r     <= accum_nxt;
      tok_start_r <= tok_start_nxt;
      tok_len_r   <= tok_len_nxt;
      int_ok_r    <= int_ok_nxt;
      ret_ok_r    <= ret_ok_nxt;
      byte_pos_r  <= byte_pos_nxt;
      tok_cnt_r   <= tok_cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= ent0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + QPTR_W'(1)] <= ent1;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPTR_W'(push_n);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + QCNT_W'(push_n) - QCNT_W'(out_fire);
    end
  end

  // Handshake: take a byte only when two records fit
  assign in_ready  = (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (q_cnt_r != '0);

  // Result fields
  assign out_kind        = q_r[rd_ptr_r].kind;
  assign out_num_value   = $signed(q_r[rd_ptr_r].num_value);
  assign out_sym_char    = q_r[rd_ptr_r].sym_char;
  assign out_start_pos   = q_r[rd_ptr_r].start_pos;
  assign out_text_len    = q_r[rd_ptr_r].text_len;
  assign out_token_index = q_r[rd_ptr_r].token_index;
  assign out_overflow    = q_r[rd_ptr_r].overflow;
  assign out_last_of_run = q_r[rd_ptr_r].last_of_run;

endmodule
